### hw/rtl/lbhr_pkg.sv
package lbhr_pkg;

  // Field widths
  localparam int unsigned IP_W    = 32;
  localparam int unsigned MAC_W   = 48;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned CSUM_W  = 16;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 48;

  // Checksum accumulator: nine 16-bit terms need four carry bits
  localparam int unsigned SUM_W = 20;

  // Header constants
  localparam logic [LEN_W-1:0]  ETH_HDR_BYTES  = 16'd14;
  localparam logic [LEN_W-1:0]  IPV4_MIN_BYTES = 16'd34;
  localparam logic [15:0]       ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [BYTE_W-1:0] PROTO_TCP      = 8'd6;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CLIENT_IP          = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_BACKEND_IP   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_BACKEND_IP  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VIRTUAL_IP         = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CLIENT_ETH_ADDR    = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_BACKEND_MAC  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_BACKEND_MAC = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_VIRTUAL_MAC        = 4'd7;

  typedef enum logic [1:0] {
    VERDICT_ABORT = 2'd0,
    VERDICT_PASS  = 2'd1,
    VERDICT_TX    = 2'd2
  } verdict_t;

  // Endpoint table as seen by the rewrite logic
  typedef struct packed {
    logic [IP_W-1:0]  client_ip;
    logic [IP_W-1:0]  first_backend_ip;
    logic [IP_W-1:0]  second_backend_ip;
    logic [IP_W-1:0]  virtual_ip;
    logic [MAC_W-1:0] client_eth_addr;
    logic [MAC_W-1:0] first_backend_mac;
    logic [MAC_W-1:0] second_backend_mac;
    logic [MAC_W-1:0] virtual_mac;
  } cfg_regs_t;

  // One parsed header
  typedef struct packed {
    logic [LEN_W-1:0]  frame_length;
    logic [15:0]       ether_type;
    logic [31:0]       ip_first_word;
    logic [31:0]       ip_second_word;
    logic [BYTE_W-1:0] time_to_live;
    logic [BYTE_W-1:0] ip_protocol;
    logic [IP_W-1:0]   source_ip;
    logic [IP_W-1:0]   destination_ip;
    logic              pick_second;
  } in_item_t;

  // One verdict with rewritten fields
  typedef struct packed {
    verdict_t          verdict;
    logic [IP_W-1:0]   new_source_ip;
    logic [IP_W-1:0]   new_destination_ip;
    logic [MAC_W-1:0]  new_source_mac;
    logic [MAC_W-1:0]  new_destination_mac;
    logic [CSUM_W-1:0] header_checksum;
  } out_item_t;

endpackage

### hw/rtl/lbhr_ifs.sv
interface lbhr_in_if
  import lbhr_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [LEN_W-1:0]  frame_length;
  logic [15:0]       ether_type;
  logic [31:0]       ip_first_word;
  logic [31:0]       ip_second_word;
  logic [BYTE_W-1:0] time_to_live;
  logic [BYTE_W-1:0] ip_protocol;
  logic [IP_W-1:0]   source_ip;
  logic [IP_W-1:0]   destination_ip;
  logic              pick_second;

  modport source (
    output valid, frame_length, ether_type, ip_first_word, ip_second_word,
           time_to_live, ip_protocol, source_ip, destination_ip, pick_second,
    input  ready
  );
  modport sink (
    input  valid, frame_length, ether_type, ip_first_word, ip_second_word,
           time_to_live, ip_protocol, source_ip, destination_ip, pick_second,
    output ready
  );
endinterface

interface lbhr_out_if
  import lbhr_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [1:0]        verdict;
  logic [IP_W-1:0]   new_source_ip;
  logic [IP_W-1:0]   new_destination_ip;
  logic [MAC_W-1:0]  new_source_mac;
  logic [MAC_W-1:0]  new_destination_mac;
  logic [CSUM_W-1:0] header_checksum;

  modport source (
    output valid, verdict, new_source_ip, new_destination_ip, new_source_mac,
           new_destination_mac, header_checksum,
    input  ready
  );
  modport sink (
    input  valid, verdict, new_source_ip, new_destination_ip, new_source_mac,
           new_destination_mac, header_checksum,
    output ready
  );
endinterface

interface lbhr_cfg_if
  import lbhr_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/lbhr_cfg_regs.sv
module lbhr_cfg_regs
  import lbhr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  lbhr_cfg_if.sink    cfg_bus,
  output cfg_regs_t   regs
);

  cfg_regs_t regs_r;

  // Writes always complete; unknown indexes are dropped
  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= '0;
    end else if (cfg_bus.valid) begin
      case (cfg_bus.index)
        REG_CLIENT_IP:          regs_r.client_ip          <= cfg_bus.data[IP_W-1:0];
        REG_FIRST_BACKEND_IP:   regs_r.first_backend_ip   <= cfg_bus.data[IP_W-1:0];
        REG_SECOND_BACKEND_IP:  regs_r.second_backend_ip  <= cfg_bus.data[IP_W-1:0];
        REG_VIRTUAL_IP:         regs_r.virtual_ip         <= cfg_bus.data[IP_W-1:0];
        REG_CLIENT_ETH_ADDR:    regs_r.client_eth_addr    <= cfg_bus.data[MAC_W-1:0];
        REG_FIRST_BACKEND_MAC:  regs_r.first_backend_mac  <= cfg_bus.data[MAC_W-1:0];
        REG_SECOND_BACKEND_MAC: regs_r.second_backend_mac <= cfg_bus.data[MAC_W-1:0];
        REG_VIRTUAL_MAC:        regs_r.virtual_mac        <= cfg_bus.data[MAC_W-1:0];
        default: ;
      endcase
    end
  end

  assign regs = regs_r;

endmodule

### hw/rtl/lbhr_rewrite.sv
module lbhr_rewrite
  import lbhr_pkg::*;
(
  input  cfg_regs_t regs,
  input  in_item_t  item,
  output out_item_t result
);

  verdict_t          verdict;
  logic              from_client;
  logic [IP_W-1:0]   dst_ip;
  logic [MAC_W-1:0]  dst_mac;
  logic [SUM_W-1:0]  sum;
  logic [16:0]       fold1;
  logic [16:0]       fold2;
  logic [CSUM_W-1:0] csum;

  // Classification, first matching rule wins
  always_comb begin
    if (item.frame_length < ETH_HDR_BYTES) begin
      verdict = VERDICT_ABORT;
    end else if (item.ether_type != ETHERTYPE_IPV4) begin
      verdict = VERDICT_PASS;
    end else if (item.frame_length < IPV4_MIN_BYTES) begin
      verdict = VERDICT_ABORT;
    end else if (item.ip_protocol != PROTO_TCP) begin
      verdict = VERDICT_PASS;
    end else begin
      verdict = VERDICT_TX;
    end
  end

  // Client traffic goes to a backend, everything else back to the client
  assign from_client = (item.source_ip == regs.client_ip);

  always_comb begin
    if (!from_client) begin
      dst_ip  = regs.client_ip;
      dst_mac = regs.client_eth_addr;
    end else if (item.pick_second) begin
      dst_ip  = regs.second_backend_ip;
      dst_mac = regs.second_backend_mac;
    end else begin
      dst_ip  = regs.first_backend_ip;
      dst_mac = regs.first_backend_mac;
    end
  end

  // Header checksum: nine 16-bit words, checksum word as zero
  assign sum = SUM_W'(item.ip_first_word[31:16]) + SUM_W'(item.ip_first_word[15:0])
             + SUM_W'(item.ip_second_word[31:16]) + SUM_W'(item.ip_second_word[15:0])
             + SUM_W'({item.time_to_live, item.ip_protocol})
             + SUM_W'(regs.virtual_ip[31:16]) + SUM_W'(regs.virtual_ip[15:0])
             + SUM_W'(dst_ip[31:16]) + SUM_W'(dst_ip[15:0]);

  // Two end-around carry folds, then complement
  assign fold1 = 17'(sum[15:0]) + 17'(sum[SUM_W-1:16]);
  assign fold2 = 17'(fold1[15:0]) + 17'(fold1[16]);
  assign csum  = ~fold2[15:0];

  // Non-transmit verdicts carry zeroed fields
  always_comb begin
    result         = '0;
    result.verdict = verdict;
    if (verdict == VERDICT_TX) begin
      result.new_source_ip       = regs.virtual_ip;
      result.new_destination_ip  = dst_ip;
      result.new_source_mac      = regs.virtual_mac;
      result.new_destination_mac = dst_mac;
      result.header_checksum     = csum;
    end
  end

endmodule

### hw/rtl/lb_ipv4_header_rewrite_core.sv
// IPv4 load-balancer header rewrite. Each beat on in_bus carries the parsed
// header fields of one Ethernet frame; exactly one beat on out_bus answers it
// with a verdict (abort, pass, transmit) and, on transmit, the rewritten
// addresses and recomputed IPv4 header checksum (other fields are zero).
// The path is an input register, one level of rewrite/checksum logic and an
// output register: the input register holds an accepted header beat until
// out_bus can advance; the output register then takes its verdict and drives
// valid. One header is accepted every cycle while out_bus keeps up; a stall on
// out_bus backs up through both registers. Endpoint addresses are written
// through cfg_bus (one beat per register, index 0..7, others ignored; ready
// is always high) and must only change while no header is in flight.
module lb_ipv4_header_rewrite_core
  import lbhr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  lbhr_in_if.sink    in_bus,
  lbhr_out_if.source out_bus,
  lbhr_cfg_if.sink   cfg_bus
);

  cfg_regs_t regs;
  in_item_t  in_item;
  in_item_t  s1_item_r;
  logic      s1_valid_r;
  out_item_t out_item_nxt;
  out_item_t out_item_r;
  logic      out_valid_r;
  logic      out_adv;

  lbhr_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_bus (cfg_bus),
    .regs    (regs)
  );

  // Gather input beat
  assign in_item.frame_length   = in_bus.frame_length;
  assign in_item.ether_type     = in_bus.ether_type;
  assign in_item.ip_first_word  = in_bus.ip_first_word;
  assign in_item.ip_second_word = in_bus.ip_second_word;
  assign in_item.time_to_live   = in_bus.time_to_live;
  assign in_item.ip_protocol    = in_bus.ip_protocol;
  assign in_item.source_ip      = in_bus.source_ip;
  assign in_item.destination_ip = in_bus.destination_ip;
  assign in_item.pick_second    = in_bus.pick_second;

  // Pipeline flow control
  assign out_adv      = !out_valid_r || out_bus.ready;
  assign in_bus.ready = !s1_valid_r || out_adv;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      s1_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.ready && in_bus.valid) begin
      s1_item_r <= in_item;
    end
  end

  lbhr_rewrite u_rewrite (
    .regs   (regs),
    .item   (s1_item_r),
    .result (out_item_nxt)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s1_valid_r) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_bus.valid               = out_valid_r;
  assign out_bus.verdict             = out_item_r.verdict;
  assign out_bus.new_source_ip       = out_item_r.new_source_ip;
  assign out_bus.new_destination_ip  = out_item_r.new_destination_ip;
  assign out_bus.new_source_mac      = out_item_r.new_source_mac;
  assign out_bus.new_destination_mac = out_item_r.new_destination_mac;
  assign out_bus.header_checksum     = out_item_r.header_checksum;

endmodule
